>>> rtl/dithered_plane_pixel_packer_core_macros.svh
// Assertion macros used by the checker file of the pixel packer.
// No dependencies; clocked on clock, with reset as the disable condition of DPPC_ASSERT only.
`ifndef DITHERED_PLANE_PIXEL_PACKER_CORE_MACROS_SVH
`define DITHERED_PLANE_PIXEL_PACKER_CORE_MACROS_SVH

// Checked at every edge outside reset.
`define DPPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define DPPC_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/dppc_pkg.sv
// Shared constants, codes and types of the dithered plane pixel packer.
// No dependencies; imported by the core and by its checker.
package dppc_pkg;

   localparam int PALETTE_BANKS = 14;
   localparam int FRAME_ROWS    = 200;

   localparam int BANK_WORDS    = 512;
   localparam int LUT_DEPTH     = PALETTE_BANKS * BANK_WORDS;
   // Each half of a colour's word pair lives in its own memory.
   localparam int LUT_ROWS      = LUT_DEPTH / 2;
   localparam int LUT_ROW_W     = $clog2(LUT_ROWS);

   localparam int PAIRS_PER_ROW = 160;

   // One shadow row holds the low plane byte and the high plane byte
   // that sits 0x8000 above it.
   localparam int SHADOW_ROW_W  = 15;
   localparam int SHADOW_ROWS   = 2 ** SHADOW_ROW_W;

   localparam int FIFO_DEPTH    = 8;
   localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

   localparam logic [15:0] MASK_LEFT_FIRST   = 16'hC0C0;
   localparam logic [15:0] MASK_LEFT_SECOND  = 16'h3030;
   localparam logic [15:0] MASK_RIGHT_FIRST  = 16'h0C0C;
   localparam logic [15:0] MASK_RIGHT_SECOND = 16'h0303;

   localparam logic KIND_LUT_WRITE = 1'b0;
   localparam logic KIND_PIXEL     = 1'b1;

   typedef struct packed {
      logic [15:0] vram_address;
      logic [7:0]  vram_byte;
      logic        last;
   } rsp_entry_type;

endpackage

>>> rtl/dithered_plane_pixel_packer_core.sv
// Dithered plane pixel packer: converts indexed pixel pairs into plane bytes
// and emits only the video writes that change memory contents.
// Depends on dppc_pkg.
//
// Channels: req_ carries lookup-write items (kind 0) and pixel-pair items
// (kind 1); rsp_ carries video byte writes; csr_ writes the palette bank
// select and is always ready. All use valid/ready, a transfer at a rising
// edge with both high.
// A lookup write may be followed by another item in the next cycle. A pixel
// pair reads the single read port of each lookup memory twice (left colour,
// then right colour), so req_ready stays low while it holds them. Its results
// pass the first and second stages, then enter a small output queue and show
// on rsp_ as soon as they are queued; the low byte comes before the high
// byte and last marks the final one.
// The shadow memory is read as the item leaves the first stage and written
// as it leaves the second, before the next item can read it.
// After reset the shadow copy of video memory is cleared one row a cycle,
// all 32768 rows; req_ready stays low meanwhile.
// When the receiver stalls, the queue fills and req_ready drops until there
// is room for the two results of another item.
module dithered_plane_pixel_packer_core
   import dppc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_palette_select,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [12:0] req_lut_index,
   input  logic [15:0] req_lut_value,
   input  logic [7:0]  req_row,
   input  logic [7:0]  req_pair_column,
   input  logic [7:0]  req_left_pixel,
   input  logic [7:0]  req_right_pixel,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_vram_address,
   output logic [7:0]  rsp_vram_byte,
   output logic        rsp_last
);

   // Configuration.
   logic [3:0] palette_ff;

   // Lookup memories, one per word half.
   logic [15:0] lut_even [0:LUT_ROWS-1];
   logic [15:0] lut_odd  [0:LUT_ROWS-1];
   logic [15:0] lut_even_q_ff, lut_odd_q_ff;
   logic        lut_ok_ff;

   // Shadow of video memory.
   logic [15:0] shadow [0:SHADOW_ROWS-1];
   logic [15:0] shd_q_ff;

   // Clearing pass.
   logic                    clr_busy_ff, clr_busy_in;
   logic [SHADOW_ROW_W-1:0] clr_cnt_ff, clr_cnt_in;

   // First stage of a pixel pair.
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_ok_ff;
   logic [7:0] s1_row_ff, s1_col_ff, s1_right_ff;

   // Second stage of a pixel pair.
   logic                    s2_valid_ff, s2_valid_in;
   logic [SHADOW_ROW_W-1:0] s2_addr_ff;
   logic [15:0]             left_even_ff, left_odd_ff;

   // Output queue.
   rsp_entry_type           fifo_ff [0:FIFO_DEPTH-1];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;

   logic                    req_xfer, pix_xfer, lut_we, bank_ok, pair_ok;
   logic [LUT_ROW_W-1:0]    lut_ra, lut_wa;
   logic [15:0]             even_w, odd_w, word;
   logic [12:0]             plane_offset;
   logic [SHADOW_ROW_W-1:0] s1_addr, shd_wa;
   logic                    shd_we;
   logic [15:0]             shd_wd;
   logic                    diff_lo, diff_hi, rsp_xfer, room;
   logic [1:0]              push_n;
   rsp_entry_type           ent_lo, ent_hi, head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         palette_ff <= csr_palette_select;
      end
   end

   assign req_xfer = req_valid && req_ready;
   assign pix_xfer = req_xfer && (req_kind == KIND_PIXEL);
   assign lut_we   = req_xfer && (req_kind == KIND_LUT_WRITE)
                     && ({1'b0, req_lut_index} < 14'(LUT_DEPTH));
   assign lut_wa   = LUT_ROW_W'(req_lut_index[12:1]);
   assign bank_ok  = {1'b0, palette_ff} < 5'(PALETTE_BANKS);
   assign pair_ok  = (req_row < 8'(FRAME_ROWS)) && (req_pair_column < 8'(PAIRS_PER_ROW));

   // The left colour is read as the item transfers, the right one while it sits in the first stage.
   always_comb begin
      lut_ra = '0;
      if (bank_ok) begin
         if (s1_valid_ff) begin
            lut_ra = LUT_ROW_W'({palette_ff, s1_right_ff});
         end else begin
            lut_ra = LUT_ROW_W'({palette_ff, req_left_pixel});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (lut_we && !req_lut_index[0]) begin
         lut_even[lut_wa] <= req_lut_value;
      end
      if (lut_we && req_lut_index[0]) begin
         lut_odd[lut_wa] <= req_lut_value;
      end
      lut_even_q_ff <= lut_even[lut_ra];
      lut_odd_q_ff  <= lut_odd[lut_ra];
      lut_ok_ff     <= bank_ok;
   end

   assign even_w = lut_ok_ff ? lut_even_q_ff : '0;
   assign odd_w  = lut_ok_ff ? lut_odd_q_ff  : '0;

   // (row/4)*160 + column, with row%4 selecting the plane bank above it.
   assign plane_offset = 13'({s1_row_ff[7:2], 7'b0}) + 13'({s1_row_ff[7:2], 5'b0})
                         + 13'(s1_col_ff);
   assign s1_addr      = {s1_row_ff[1:0], plane_offset};

   assign word = (left_even_ff & MASK_LEFT_FIRST) | (left_odd_ff & MASK_LEFT_SECOND)
               | (even_w & MASK_RIGHT_FIRST) | (odd_w & MASK_RIGHT_SECOND);

   assign diff_lo = s2_valid_ff && (word[7:0] != shd_q_ff[7:0]);
   assign diff_hi = s2_valid_ff && (word[15:8] != shd_q_ff[15:8]);
   assign push_n  = 2'(diff_lo) + 2'(diff_hi);

   assign ent_lo = '{vram_address: {1'b0, s2_addr_ff}, vram_byte: word[7:0],
                     last: !diff_hi};
   assign ent_hi = '{vram_address: {1'b1, s2_addr_ff}, vram_byte: word[15:8],
                     last: 1'b1};

   assign shd_we = clr_busy_ff || s2_valid_ff;
   assign shd_wa = clr_busy_ff ? clr_cnt_ff : s2_addr_ff;
   assign shd_wd = clr_busy_ff ? '0 : word;

   always_ff @(posedge clock) begin
      if (shd_we) begin
         shadow[shd_wa] <= shd_wd;
      end
      shd_q_ff <= shadow[s1_addr];
   end

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // An item may enter only if the queue can still take two results
   // when it reaches the end, counting what lands there this cycle.
   assign room      = (count_ff + FIFO_CNT_W'(push_n)) <= FIFO_CNT_W'(FIFO_DEPTH - 2);
   assign req_ready = !s1_valid_ff && !clr_busy_ff && room;

   assign s1_valid_in = pix_xfer;
   assign s2_valid_in = s1_valid_ff && s1_ok_ff;

   always_ff @(posedge clock) begin
      if (pix_xfer) begin
         s1_ok_ff    <= pair_ok;
         s1_row_ff   <= req_row;
         s1_col_ff   <= req_pair_column;
         s1_right_ff <= req_right_pixel;
      end
      if (s1_valid_ff) begin
         s2_addr_ff   <= s1_addr;
         left_even_ff <= even_w;
         left_odd_ff  <= odd_w;
      end
   end

   assign head             = fifo_ff[rd_ptr_ff];
   assign rsp_valid        = count_ff != '0;
   assign rsp_vram_address = head.vram_address;
   assign rsp_vram_byte    = head.vram_byte;
   assign rsp_last         = head.last;
   assign rsp_xfer         = rsp_valid && rsp_ready;

   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(rsp_xfer);
   assign count_in  = count_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (diff_lo) begin
         fifo_ff[wr_ptr_ff] <= ent_lo;
      end
      if (diff_hi) begin
         fifo_ff[diff_lo ? wr_ptr_ff + 1'b1 : wr_ptr_ff] <= ent_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

endmodule

>>> rtl/dppc_checker.sv
// Port-level checker for the pixel packer core, bound into the core module.
// Depends on dppc_pkg and dithered_plane_pixel_packer_core_macros.svh.
`include "dithered_plane_pixel_packer_core_macros.svh"

module dppc_checker
   import dppc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_vram_address,
   input logic [7:0]  rsp_vram_byte,
   input logic        rsp_last
);

   logic        pix_xfer, rsp_xfer, rsp_stall;
   logic [24:0] rsp_payload;

   assign pix_xfer    = req_valid && req_ready && (req_kind == KIND_PIXEL);
   assign rsp_xfer    = rsp_valid && rsp_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_vram_address, rsp_vram_byte, rsp_last};

   // A pixel pair keeps the lookup read ports busy once it has transferred.
   `DPPC_ASSERT(a_pair_busy, pix_xfer |=> !req_ready, "req_ready high right after a pixel pair")
   // Both bytes of a pair enter the queue together, so a non-final one has a follower.
   `DPPC_ASSERT(a_last_follow, rsp_xfer && !rsp_last |=> rsp_valid, "result missing after non-final one")
   // Results first appear once the pixel pair that caused them has passed both stages.
   `DPPC_ASSERT(a_rsp_latency, $rose(rsp_valid) |-> $past(pix_xfer, 3), "result without a pixel pair")
   `DPPC_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled result changed")
   // Reset empties the queue and starts the shadow clearing pass.
   `DPPC_ASSERT_RST(a_after_reset, $fell(reset) |-> !req_ready && !rsp_valid, "not idle after reset")

endmodule

bind dithered_plane_pixel_packer_core dppc_checker u_dppc_checker (.*);
